FILE: rtl/core/resp_bulk_array_parser_macros.svh
// ----------------------------------------------------------------------------
// resp_bulk_array_parser_macros.svh
// Assertion macros used by the checker file of the parser.
// ----------------------------------------------------------------------------
`ifndef RESP_BULK_ARRAY_PARSER_MACROS_SVH
`define RESP_BULK_ARRAY_PARSER_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define RBAP_ASSERT_ALWAYS(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rbap check failed: invariant");

// Same-cycle implication.
`define RBAP_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbap check failed: implication");

// Next-cycle implication.
`define RBAP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbap check failed: next-cycle implication");

`endif

FILE: rtl/core/rbap_pkg.sv
// ----------------------------------------------------------------------------
// rbap_pkg
// Shared types and codes of the bulk array parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rbap_pkg;

  // Result kind codes
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // One queue entry: results caused by one input byte (payload first)
  typedef struct packed {
    logic       pay_v;
    logic [7:0] payload_byte;
    logic [3:0] token_index;
    logic       token_done;
    logic       st_v;
    logic       status;
    logic [4:0] element_total;
  } rec_t;

  // One result as shown on the output ports
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [3:0] token_index;
    logic       token_done;
    logic       status;
    logic [4:0] element_total;
    logic       run_last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/rbap_front.sv
// ----------------------------------------------------------------------------
// rbap_front
// Byte parser: walks the array header and element headers, tracks payload
// length and builds one queue entry per byte that causes results.
// ----------------------------------------------------------------------------
`default_nettype none

module rbap_front import rbap_pkg::*; #(
  parameter int MAX_ELEMENTS = 16,
  parameter int BUFFER_BYTES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [4:0] cfg_data,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       message_end,
  output logic            rec_valid,
  output rec_t            rec
);

  localparam int CNT_W   = 11;
  localparam int LEN_W   = $clog2(BUFFER_BYTES + 2);
  localparam int NUM_W   = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int EL_W    = $clog2(MAX_ELEMENTS + 1);
  localparam int CNT_CAP = 2047;
  localparam int LEN_CAP = BUFFER_BYTES + 1;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [1:0] SKIP_BYTES = 2'd2;

  typedef enum logic [8:0] {
    PH_STAR     = 9'b000000001,
    PH_NUM_SIGN = 9'b000000010,
    PH_NUM_DIG  = 9'b000000100,
    PH_NUM_CR   = 9'b000001000,
    PH_NUM_LF   = 9'b000010000,
    PH_DOLLAR   = 9'b000100000,
    PH_PAYLOAD  = 9'b001000000,
    PH_SKIP     = 9'b010000000,
    PH_BAD      = 9'b100000000
  } phase_t;

  phase_t             phase, phase_next;
  logic               in_length, in_length_next;
  logic [CNT_W-1:0]   element_target, element_target_next;
  logic [LEN_W-1:0]   length_left, length_left_next;
  logic [EL_W-1:0]    elements_done, elements_done_next;
  logic [1:0]         skip_left, skip_left_next;
  logic               saw_minus, saw_minus_next;
  logic               message_closed, message_closed_next;
  logic [4:0]         token_limit;

  logic               is_digit;
  logic [3:0]         digit_val;
  logic [NUM_W-1:0]   acc_cur;
  logic [NUM_W+3:0]   acc_mul;
  logic [NUM_W+3:0]   acc_cap;
  logic [NUM_W-1:0]   acc_sat;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   cnt_eff;
  logic [CNT_W-1:0]   tgt_new;
  logic               len_bad;
  logic [LEN_W-1:0]   len_dec;
  logic [EL_W-1:0]    done_inc;
  logic               done_last;
  logic               do_complete;

  // Digit accumulate with saturation (count or length)
  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit_val = 4'(data_byte - CH_ZERO);
  assign acc_cur   = in_length ? NUM_W'(length_left) : NUM_W'(element_target);
  assign acc_mul   = (NUM_W+4)'({acc_cur, 3'b000}) + (NUM_W+4)'({acc_cur, 1'b0})
                   + (NUM_W+4)'(digit_val);
  assign acc_cap   = in_length ? (NUM_W+4)'(LEN_CAP) : (NUM_W+4)'(CNT_CAP);
  assign acc_sat   = (acc_mul > acc_cap) ? NUM_W'(acc_cap) : NUM_W'(acc_mul);

  // Element count after the array header: min(count, limit, MAX_ELEMENTS)
  assign lim     = (CNT_W'(token_limit) > CNT_W'(MAX_ELEMENTS)) ?
                   CNT_W'(MAX_ELEMENTS) : CNT_W'(token_limit);
  assign cnt_eff = saw_minus ? '0 : element_target;
  assign tgt_new = (cnt_eff < lim) ? cnt_eff : lim;

  // Element length checks and payload countdown
  assign len_bad = (saw_minus && (length_left != '0)) ||
                   (length_left > LEN_W'(BUFFER_BYTES));
  assign len_dec = (length_left != '0) ? length_left - 1'b1 : length_left;

  // Element completion
  assign done_inc  = elements_done + 1'b1;
  assign done_last = CNT_W'(done_inc) >= element_target;

  // Next-state and entry build
  always_comb begin
    phase_next          = phase;
    in_length_next      = in_length;
    element_target_next = element_target;
    length_left_next    = length_left;
    elements_done_next  = elements_done;
    skip_left_next      = skip_left;
    saw_minus_next      = saw_minus;
    message_closed_next = message_closed;
    do_complete         = 1'b0;
    rec                 = '0;

    if (!message_closed) begin
      unique case (phase)
        PH_STAR: begin
          if (data_byte == CH_STAR) begin
            in_length_next      = 1'b0;
            saw_minus_next      = 1'b0;
            element_target_next = '0;
            phase_next          = PH_NUM_SIGN;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_DOLLAR: begin
          if (data_byte == CH_DOLLAR) begin
            in_length_next   = 1'b1;
            saw_minus_next   = 1'b0;
            length_left_next = '0;
            phase_next       = PH_NUM_SIGN;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_NUM_SIGN, PH_NUM_DIG, PH_NUM_CR: begin
          if (phase == PH_NUM_SIGN && data_byte == CH_MINUS) begin
            saw_minus_next = 1'b1;
            phase_next     = PH_NUM_DIG;
          end else if (phase == PH_NUM_SIGN && data_byte == CH_PLUS) begin
            phase_next = PH_NUM_DIG;
          end else if (phase != PH_NUM_CR && is_digit) begin
            if (in_length) length_left_next = LEN_W'(acc_sat);
            else element_target_next = CNT_W'(acc_sat);
            phase_next = PH_NUM_DIG;
          end else begin
            phase_next = (data_byte == CH_CR) ? PH_NUM_LF : PH_NUM_CR;
          end
        end
        PH_NUM_LF: begin
          if (data_byte == CH_LF) begin
            if (!in_length) begin
              element_target_next = tgt_new;
              elements_done_next  = '0;
              if (tgt_new == '0) begin
                rec.st_v            = 1'b1;
                rec.status          = STATUS_BAD;
                message_closed_next = 1'b1;
              end else begin
                phase_next = PH_DOLLAR;
              end
            end else if (len_bad) begin
              phase_next = PH_BAD;
            end else if (length_left == '0) begin
              do_complete = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else if (data_byte != CH_CR) begin
            phase_next = PH_NUM_CR;
          end
        end
        PH_PAYLOAD: begin
          length_left_next = len_dec;
          rec.pay_v        = 1'b1;
          rec.payload_byte = data_byte;
          rec.token_index  = 4'(elements_done);
          rec.token_done   = (len_dec == '0);
          do_complete      = (len_dec == '0);
        end
        PH_SKIP: begin
          skip_left_next = (skip_left != 2'd0) ? skip_left - 1'b1 : skip_left;
          if (skip_left_next == 2'd0) phase_next = PH_DOLLAR;
        end
        PH_BAD: begin
        end
        default: begin
        end
      endcase
    end

    // Element done: ok status or skip the trailing CRLF
    if (do_complete) begin
      elements_done_next = done_inc;
      if (done_last) begin
        rec.st_v            = 1'b1;
        rec.status          = STATUS_OK;
        rec.element_total   = 5'(done_inc);
        message_closed_next = 1'b1;
      end else begin
        skip_left_next = SKIP_BYTES;
        phase_next     = PH_SKIP;
      end
    end

    // Message end: early-end status, then back to the start
    if (message_end) begin
      if (!message_closed_next) begin
        rec.st_v          = 1'b1;
        rec.status        = STATUS_BAD;
        rec.element_total = '0;
      end
      phase_next          = PH_STAR;
      in_length_next      = 1'b0;
      element_target_next = '0;
      length_left_next    = '0;
      elements_done_next  = '0;
      skip_left_next      = 2'd0;
      saw_minus_next      = 1'b0;
      message_closed_next = 1'b0;
    end
  end

  assign rec_valid = accept && (rec.pay_v || rec.st_v);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_STAR;
      in_length      <= 1'b0;
      element_target <= '0;
      length_left    <= '0;
      elements_done  <= '0;
      skip_left      <= 2'd0;
      saw_minus      <= 1'b0;
      message_closed <= 1'b0;
      token_limit    <= 5'd16;
    end else begin
      if (cfg_write) token_limit <= cfg_data;
      if (accept) begin
        phase          <= phase_next;
        in_length      <= in_length_next;
        element_target <= element_target_next;
        length_left    <= length_left_next;
        elements_done  <= elements_done_next;
        skip_left      <= skip_left_next;
        saw_minus      <= saw_minus_next;
        message_closed <= message_closed_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rbap_queue.sv
// ----------------------------------------------------------------------------
// rbap_queue
// Short register queue of parsed entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rbap_queue import rbap_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t wdata,
  output logic      full,
  input  wire logic pop,
  output rec_t      rdata,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wdata;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rbap_back.sv
// ----------------------------------------------------------------------------
// rbap_back
// Result issue: splits each queue entry into one or two results and holds
// the oldest result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rbap_back import rbap_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire rec_t q_data,
  input  wire logic q_empty,
  output logic      q_pop,
  input  wire logic res_pop,
  output logic      res_empty,
  output res_t      res
);

  logic out_valid;
  logic pend_valid;
  res_t pend;
  res_t pay_res;
  res_t st_res;
  logic load;

  // Result forms of a queue entry
  always_comb begin
    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = q_data.payload_byte;
    pay_res.token_index  = q_data.token_index;
    pay_res.token_done   = q_data.token_done;
    pay_res.run_last     = !q_data.st_v;

    st_res               = '0;
    st_res.kind          = KIND_STATUS;
    st_res.status        = q_data.status;
    st_res.element_total = q_data.element_total;
    st_res.run_last      = 1'b1;
  end

  assign load      = !out_valid || res_pop;
  assign q_pop     = load && !pend_valid && !q_empty;
  assign res_empty = !out_valid;

  // Output register and held second result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        res        <= pend;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        if (q_data.pay_v) begin
          res        <= pay_res;
          pend       <= st_res;
          pend_valid <= q_data.st_v;
        end else begin
          res <= st_res;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/resp_bulk_array_parser.sv
// ----------------------------------------------------------------------------
// resp_bulk_array_parser
// Streaming parser for an array of bulk strings: emits payload bytes tagged
// with element index and end mark, and one ok/invalid status per message.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake      Transfer when
// input     in         push / full    push && !full
// result    out        empty / pop    pop && !empty
// config    in         cfg_write      cfg_write (token_limit <= cfg_data)
//
// One byte is taken per cycle while the queue is not full; the front parser
// updates its state in the accepting cycle and queues an entry for bytes that
// cause results. A payload byte that closes an element and the message yields
// two results, payload then status, issued in turn from the output register;
// the sustained rate is one result per cycle while pop is held.
// full rises when the 4-entry queue between parser and issue stage fills.
// No clearing pass at reset; a result goes via the queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_bulk_array_parser import rbap_pkg::*; #(
  parameter int MAX_ELEMENTS = 16,
  parameter int BUFFER_BYTES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       message_end,
  input  wire logic       cfg_write,
  input  wire logic [4:0] cfg_data,
  output logic            empty,
  input  wire logic       pop,
  output logic            kind,
  output logic [7:0]      payload_byte,
  output logic [3:0]      token_index,
  output logic            token_done,
  output logic            status,
  output logic [4:0]      element_total,
  output logic            run_last
);

  localparam int QUEUE_DEPTH = 4;

  logic accept;
  logic rec_valid;
  rec_t rec;
  rec_t q_data;
  logic q_empty;
  logic q_pop;
  res_t res;

  assign accept = push && !full;

  // Front: byte parser
  rbap_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .data_byte   (data_byte),
    .message_end (message_end),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  // Entry queue
  rbap_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_valid),
    .wdata (rec),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  // Back: result issue
  rbap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign kind          = res.kind;
  assign payload_byte  = res.payload_byte;
  assign token_index   = res.token_index;
  assign token_done    = res.token_done;
  assign status        = res.status;
  assign element_total = res.element_total;
  assign run_last      = res.run_last;

endmodule

`default_nettype wire

FILE: rtl/core/rbap_checker.sv
// ----------------------------------------------------------------------------
// rbap_checker
// Port-level checks of the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "resp_bulk_array_parser_macros.svh"

module rbap_checker import rbap_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       kind,
  input wire logic [7:0] payload_byte,
  input wire logic [3:0] token_index,
  input wire logic       token_done,
  input wire logic       status,
  input wire logic [4:0] element_total,
  input wire logic       run_last
);

  // Stalled result stays put
  `RBAP_ASSERT_NEXT(a_res_hold, clk, rst, !empty && !pop,
    !empty && $stable(kind) && $stable(payload_byte) && $stable(run_last))

  // A status result always closes the results of its byte
  `RBAP_ASSERT_IMPLY(a_status_last, clk, rst, !empty && kind == KIND_STATUS, run_last)

  // Unused fields are zero; invalid status carries no count
  `RBAP_ASSERT_IMPLY(a_fields_clean, clk, rst, !empty,
    (kind == KIND_PAYLOAD) ? (status == STATUS_OK && element_total == 5'd0) :
    (payload_byte == 8'd0 && token_index == 4'd0 && !token_done &&
     (status == STATUS_OK || element_total == 5'd0)))

  // A payload result that is not last is followed at once by its status
  `RBAP_ASSERT_NEXT(a_pair_follow, clk, rst,
    !empty && pop && kind == KIND_PAYLOAD && !run_last, !empty && kind == KIND_STATUS)

endmodule

bind resp_bulk_array_parser rbap_checker u_rbap_checker (.*);

`default_nettype wire
